[rtl/core/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted segment distance package
// Shared widths, register indexes, capping constants and item types.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int COORD_W   = 32;
  localparam int PART_W    = 32;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ANG  = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int MAG_W    = SUM_W;
  localparam int RAD_W    = PROD_W;
  localparam int LEN_W    = RAD_W / 2;
  localparam int DIST_W   = 41;
  localparam int DSUM_W   = DIST_W + 1;
  localparam int SQ_W     = 2 * DSUM_W;
  localparam int SQSUM_W  = 2 * DIST_W;
  localparam int WPROD_W  = WEIGHT_W + PART_W;
  localparam int WSUM_W   = WPROD_W + 2;
  localparam int MUL_LAT  = 4;

  localparam logic [63:0] DIST_CAP = 64'h0000_0100_0000_0000;
  localparam logic [63:0] PART_CAP = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic [PART_W-1:0] total_distance;
    logic [PART_W-1:0] perpendicular_part;
    logic [PART_W-1:0] parallel_part;
    logic [PART_W-1:0] angle_part;
    logic              degenerate;
  } out_item_t;

endpackage

[rtl/core/wsd_delay.sv]
// ----------------------------------------------------------------------------
// Delay line
// Shift register that carries a value through D registers; a plain wire when D is zero.
// ----------------------------------------------------------------------------
module wsd_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (D == 0) begin : g_wire
      assign q = d;
    end else begin : g_regs
      logic [W-1:0] taps [D];
      always_ff @(posedge clk) begin
        taps[0] <= d;
        for (int i = 1; i < D; i++) begin
          taps[i] <= taps[i-1];
        end
      end
      assign q = taps[D-1];
    end
  endgenerate

endmodule

[rtl/core/wsd_mul.sv]
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Four half-width partial products, summed and signed over four stages.
// ----------------------------------------------------------------------------
module wsd_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;

  logic [W-1:0]     ma, mb;
  logic             neg1, neg2, neg3;
  logic [2*H-1:0]   pp_ll, pp_lh, pp_hl, pp_hh;
  logic [2*W-1:0]   mag_sum;
  logic [PW-1:0]    wide_sum;

  always_comb begin
    wide_sum = PW'(pp_ll) + (PW'(pp_lh) << H) + (PW'(pp_hl) << H) + (PW'(pp_hh) << (2 * H));
  end

  always_ff @(posedge clk) begin
    ma      <= a[W-1] ? W'(~a + 1'b1) : W'(a);
    mb      <= b[W-1] ? W'(~b + 1'b1) : W'(b);
    neg1    <= a[W-1] ^ b[W-1];
    pp_ll   <= (2*H)'(ma[H-1:0]) * (2*H)'(mb[H-1:0]);
    pp_lh   <= (2*H)'(ma[H-1:0]) * (2*H)'(mb[W-1:H]);
    pp_hl   <= (2*H)'(ma[W-1:H]) * (2*H)'(mb[H-1:0]);
    pp_hh   <= (2*H)'(ma[W-1:H]) * (2*H)'(mb[W-1:H]);
    neg2    <= neg1;
    mag_sum <= wide_sum[2*W-1:0];
    neg3    <= neg2;
    p       <= neg3 ? $signed(~mag_sum + 1'b1) : $signed(mag_sum);
  end

endmodule

[rtl/core/wsd_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Two radicand bits and one root bit per stage, floor of the root.
// ----------------------------------------------------------------------------
module wsd_sqrt #(
  parameter int VW = 66
) (
  input  logic              clk,
  input  logic [VW-1:0]     v,
  output logic [VW/2-1:0]   root
);

  localparam int RW  = VW / 2;
  localparam int RMW = RW + 3;

  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [VW-1:0]  val_q  [RW];

  generate
    for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RMW-1:0] rem_p, t, trial;
      logic [RW-1:0]  root_p;
      logic [VW-1:0]  val_p;
      if (i == 0) begin : g_first
        assign rem_p  = '0;
        assign root_p = '0;
        assign val_p  = v;
      end else begin : g_next
        assign rem_p  = rem_q[i-1];
        assign root_p = root_q[i-1];
        assign val_p  = val_q[i-1];
      end
      assign t     = {rem_p[RMW-3:0], val_p[VW-1:VW-2]};
      assign trial = RMW'({root_p, 2'b01});
      always_ff @(posedge clk) begin
        if (t >= trial) begin
          rem_q[i]  <= t - trial;
          root_q[i] <= {root_p[RW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= t;
          root_q[i] <= {root_p[RW-2:0], 1'b0};
        end
        val_q[i] <= val_p << 2;
      end
    end
  endgenerate

  assign root = root_q[RW-1];

endmodule

[rtl/core/wsd_div.sv]
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Restoring division, one quotient bit per stage, then a capping stage.
// ----------------------------------------------------------------------------
module wsd_div #(
  parameter int          NW  = 67,
  parameter int          DW  = 33,
  parameter int          CW  = 32,
  parameter logic [63:0] CAP = 64'hFFFF_FFFF
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [CW-1:0] quo
);

  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] q_q   [NW];

  generate
    for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW-1:0] rem_p, den_p;
      logic [NW-1:0] num_p, q_p;
      logic [DW:0]   t;
      if (i == 0) begin : g_first
        assign rem_p = '0;
        assign den_p = den;
        assign num_p = num;
        assign q_p   = '0;
      end else begin : g_next
        assign rem_p = rem_q[i-1];
        assign den_p = den_q[i-1];
        assign num_p = num_q[i-1];
        assign q_p   = q_q[i-1];
      end
      assign t = {rem_p, num_p[NW-1]};
      always_ff @(posedge clk) begin
        if (t >= {1'b0, den_p}) begin
          rem_q[i] <= DW'(t - {1'b0, den_p});
          q_q[i]   <= {q_p[NW-2:0], 1'b1};
        end else begin
          rem_q[i] <= t[DW-1:0];
          q_q[i]   <= {q_p[NW-2:0], 1'b0};
        end
        den_q[i] <= den_p;
        num_q[i] <= num_p << 1;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (q_q[NW-1] > NW'(CAP)) begin
      quo <= CW'(CAP);
    end else begin
      quo <= q_q[NW-1][CW-1:0];
    end
  end

endmodule

[rtl/core/weighted_segment_distance_core.sv]
// ----------------------------------------------------------------------------
// Weighted segment distance core
// Perpendicular, parallel and angle distances of two segments, weighted sum.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is low except during reset.
// The result path runs through the square root of the first segment's squared
// length and then the dividers, one quotient bit per stage.
// Reset clears all valid bits and sets the three weights to 1.0.
module weighted_segment_distance_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  wsd_pkg::in_item_t                   pair,
  output logic                                result_valid,
  output wsd_pkg::out_item_t                  result,
  input  logic                                cfg_write,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsd_pkg::WEIGHT_W-1:0]        cfg_data
);

  import wsd_pkg::*;

  localparam int NUM_MUL = 14;
  localparam int LV_DIFF = 1;
  localparam int LV_PROD = LV_DIFF + MUL_LAT;
  localparam int LV_SUM  = LV_PROD + 1;
  localparam int LV_ABS  = LV_SUM + 1;
  localparam int LV_MAG  = LV_ABS + 1;
  localparam int LV_MIN1 = LV_MAG + 1;
  localparam int LV_MIN  = LV_MIN1 + 1;
  localparam int LV_LEN  = LV_SUM + LEN_W;
  localparam int LV_Q    = LV_LEN + MAG_W + 1;
  localparam int LV_SQ   = LV_Q + MUL_LAT;
  localparam int LV_SQS  = LV_SQ + 1;
  localparam int LV_PERP = LV_SQS + SQSUM_W + 1;
  localparam int LV_WGT  = LV_PERP + 1;
  localparam int LV_TSUM = LV_WGT + 1;
  localparam int LV_OUT  = LV_TSUM + 1;

  logic [WEIGHT_W-1:0] w_perp, w_par, w_ang;
  logic [LV_OUT:0]     vld;
  in_item_t            pair_q;

  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb, psx, psy, pex, pey;
  logic signed [DIFF_W-1:0] mul_a [NUM_MUL];
  logic signed [DIFF_W-1:0] mul_b [NUM_MUL];
  logic signed [PROD_W-1:0] mul_p [NUM_MUL];

  logic signed [SUM_W-1:0]  la2, lb2, crs, cre, dts, dte, cab;
  logic signed [SUM_W-1:0]  dts_q, dte_q;
  logic signed [SUM_W:0]    dsl, del;
  logic [MAG_W-1:0]         crs_mag, cre_mag, cab_mag;
  logic [MAG_W-1:0]         ds_mag, dsl_mag, de_mag, del_mag, min_s, min_e, min_all;
  logic                     deg;

  logic [MAG_W-1:0]  crs_d, cre_d, cab_d, min_d;
  logic [LEN_W-1:0]  len_a, len_b, len_a_d;
  logic [DIST_W-1:0] da, db, ang_raw;
  logic [PART_W-1:0] par_raw, par_d, ang_c, ang_d, perp_q;
  logic [DSUM_W-1:0] dsum, dsum_d;
  logic              dz, dz_d, deg_d;
  logic signed [SQ_W-1:0] sq_a, sq_b;
  logic [SQSUM_W-1:0] sq_sum;
  logic [DIST_W-1:0]  ang_lim;

  logic [PART_W-1:0]  perp_w, par_w, ang_w, perp_t, par_t, ang_t;
  logic [WPROD_W-1:0] wp_perp, wp_par, wp_ang;
  logic [WSUM_W-1:0]  tsum;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_perp <= WEIGHT_RESET;
      w_par  <= WEIGHT_RESET;
      w_ang  <= WEIGHT_RESET;
      vld    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WEIGHT_PERP: w_perp <= cfg_data;
          REG_WEIGHT_PAR:  w_par  <= cfg_data;
          REG_WEIGHT_ANG:  w_ang  <= cfg_data;
          default:         ;
        endcase
      end
      vld <= {vld[LV_OUT-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    pair_q <= pair;
    dxa <= DIFF_W'(pair_q.a_end_x) - DIFF_W'(pair_q.a_start_x);
    dya <= DIFF_W'(pair_q.a_end_y) - DIFF_W'(pair_q.a_start_y);
    dxb <= DIFF_W'(pair_q.b_end_x) - DIFF_W'(pair_q.b_start_x);
    dyb <= DIFF_W'(pair_q.b_end_y) - DIFF_W'(pair_q.b_start_y);
    psx <= DIFF_W'(pair_q.b_start_x) - DIFF_W'(pair_q.a_start_x);
    psy <= DIFF_W'(pair_q.b_start_y) - DIFF_W'(pair_q.a_start_y);
    pex <= DIFF_W'(pair_q.b_end_x) - DIFF_W'(pair_q.a_start_x);
    pey <= DIFF_W'(pair_q.b_end_y) - DIFF_W'(pair_q.a_start_y);
  end

  always_comb begin
    mul_a[0]  = dxa; mul_b[0]  = dxa;
    mul_a[1]  = dya; mul_b[1]  = dya;
    mul_a[2]  = dxb; mul_b[2]  = dxb;
    mul_a[3]  = dyb; mul_b[3]  = dyb;
    mul_a[4]  = dxa; mul_b[4]  = psy;
    mul_a[5]  = dya; mul_b[5]  = psx;
    mul_a[6]  = dxa; mul_b[6]  = pey;
    mul_a[7]  = dya; mul_b[7]  = pex;
    mul_a[8]  = dxa; mul_b[8]  = psx;
    mul_a[9]  = dya; mul_b[9]  = psy;
    mul_a[10] = dxa; mul_b[10] = pex;
    mul_a[11] = dya; mul_b[11] = pey;
    mul_a[12] = dxa; mul_b[12] = dyb;
    mul_a[13] = dya; mul_b[13] = dxb;
  end

  generate
    for (genvar g = 0; g < NUM_MUL; g++) begin : g_mul
      wsd_mul #(.W(DIFF_W)) u_mul (
        .clk (clk),
        .a   (mul_a[g]),
        .b   (mul_b[g]),
        .p   (mul_p[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    la2 <= SUM_W'(mul_p[0]) + SUM_W'(mul_p[1]);
    lb2 <= SUM_W'(mul_p[2]) + SUM_W'(mul_p[3]);
    crs <= SUM_W'(mul_p[4]) - SUM_W'(mul_p[5]);
    cre <= SUM_W'(mul_p[6]) - SUM_W'(mul_p[7]);
    dts <= SUM_W'(mul_p[8]) + SUM_W'(mul_p[9]);
    dte <= SUM_W'(mul_p[10]) + SUM_W'(mul_p[11]);
    cab <= SUM_W'(mul_p[12]) - SUM_W'(mul_p[13]);

    deg     <= (la2 == '0) || (lb2 == '0);
    dsl     <= (SUM_W+1)'(dts) - (SUM_W+1)'(la2);
    del     <= (SUM_W+1)'(dte) - (SUM_W+1)'(la2);
    dts_q   <= dts;
    dte_q   <= dte;
    crs_mag <= crs[SUM_W-1] ? MAG_W'(~crs + 1'b1) : MAG_W'(crs);
    cre_mag <= cre[SUM_W-1] ? MAG_W'(~cre + 1'b1) : MAG_W'(cre);
    cab_mag <= cab[SUM_W-1] ? MAG_W'(~cab + 1'b1) : MAG_W'(cab);

    ds_mag  <= dts_q[SUM_W-1] ? MAG_W'(~dts_q + 1'b1) : MAG_W'(dts_q);
    de_mag  <= dte_q[SUM_W-1] ? MAG_W'(~dte_q + 1'b1) : MAG_W'(dte_q);
    dsl_mag <= dsl[SUM_W] ? MAG_W'(~dsl + 1'b1) : MAG_W'(dsl);
    del_mag <= del[SUM_W] ? MAG_W'(~del + 1'b1) : MAG_W'(del);

    min_s   <= (dsl_mag < ds_mag) ? dsl_mag : ds_mag;
    min_e   <= (del_mag < de_mag) ? del_mag : de_mag;
    min_all <= (min_e < min_s) ? min_e : min_s;
  end

  wsd_sqrt #(.VW(RAD_W)) u_sqrt_a (.clk(clk), .v(la2[RAD_W-1:0]), .root(len_a));
  wsd_sqrt #(.VW(RAD_W)) u_sqrt_b (.clk(clk), .v(lb2[RAD_W-1:0]), .root(len_b));

  wsd_delay #(.W(MAG_W), .D(LV_LEN - LV_ABS)) u_dly_crs (.clk(clk), .d(crs_mag), .q(crs_d));
  wsd_delay #(.W(MAG_W), .D(LV_LEN - LV_ABS)) u_dly_cre (.clk(clk), .d(cre_mag), .q(cre_d));
  wsd_delay #(.W(MAG_W), .D(LV_LEN - LV_ABS)) u_dly_cab (.clk(clk), .d(cab_mag), .q(cab_d));
  wsd_delay #(.W(MAG_W), .D(LV_LEN - LV_MIN)) u_dly_min (.clk(clk), .d(min_all), .q(min_d));
  wsd_delay #(.W(LEN_W), .D(LV_Q - LV_LEN)) u_dly_len (.clk(clk), .d(len_a), .q(len_a_d));

  wsd_div #(.NW(MAG_W), .DW(LEN_W), .CW(DIST_W), .CAP(DIST_CAP)) u_div_da (
    .clk(clk), .num(crs_d), .den(len_a), .quo(da)
  );
  wsd_div #(.NW(MAG_W), .DW(LEN_W), .CW(DIST_W), .CAP(DIST_CAP)) u_div_db (
    .clk(clk), .num(cre_d), .den(len_a), .quo(db)
  );
  wsd_div #(.NW(MAG_W), .DW(LEN_W), .CW(PART_W), .CAP(PART_CAP)) u_div_par (
    .clk(clk), .num(min_d), .den(len_a), .quo(par_raw)
  );
  wsd_div #(.NW(MAG_W), .DW(LEN_W), .CW(DIST_W), .CAP(DIST_CAP)) u_div_ang (
    .clk(clk), .num(cab_d), .den(len_b), .quo(ang_raw)
  );

  always_comb begin
    ang_lim = (ang_raw > DIST_W'(len_a_d)) ? DIST_W'(len_a_d) : ang_raw;
  end

  always_ff @(posedge clk) begin
    ang_c <= (ang_lim > DIST_W'(PART_CAP)) ? PART_CAP[PART_W-1:0] : ang_lim[PART_W-1:0];
    dsum  <= DSUM_W'(da) + DSUM_W'(db);
    dz    <= (da == '0) && (db == '0);
  end

  wsd_mul #(.W(DSUM_W)) u_sq_a (
    .clk(clk), .a($signed({1'b0, da})), .b($signed({1'b0, da})), .p(sq_a)
  );
  wsd_mul #(.W(DSUM_W)) u_sq_b (
    .clk(clk), .a($signed({1'b0, db})), .b($signed({1'b0, db})), .p(sq_b)
  );

  always_ff @(posedge clk) begin
    sq_sum <= SQSUM_W'(sq_a) + SQSUM_W'(sq_b);
  end

  wsd_delay #(.W(DSUM_W), .D(LV_SQS - LV_Q - 1)) u_dly_dsum (.clk(clk), .d(dsum), .q(dsum_d));
  wsd_delay #(.W(1), .D(LV_PERP - LV_Q - 1)) u_dly_dz (.clk(clk), .d(dz), .q(dz_d));
  wsd_delay #(.W(PART_W), .D(LV_PERP - LV_Q)) u_dly_par (.clk(clk), .d(par_raw), .q(par_d));
  wsd_delay #(.W(PART_W), .D(LV_PERP - LV_Q - 1)) u_dly_ang (.clk(clk), .d(ang_c), .q(ang_d));
  wsd_delay #(.W(1), .D(LV_TSUM - LV_ABS)) u_dly_deg (.clk(clk), .d(deg), .q(deg_d));

  wsd_div #(.NW(SQSUM_W), .DW(DSUM_W), .CW(PART_W), .CAP(PART_CAP)) u_div_perp (
    .clk(clk), .num(sq_sum), .den(dsum_d), .quo(perp_q)
  );

  always_ff @(posedge clk) begin
    perp_w  <= dz_d ? '0 : perp_q;
    par_w   <= par_d;
    ang_w   <= ang_d;
    wp_perp <= WPROD_W'(w_perp) * WPROD_W'(dz_d ? '0 : perp_q);
    wp_par  <= WPROD_W'(w_par) * WPROD_W'(par_d);
    wp_ang  <= WPROD_W'(w_ang) * WPROD_W'(ang_d);

    tsum   <= WSUM_W'(wp_perp) + WSUM_W'(wp_par) + WSUM_W'(wp_ang);
    perp_t <= perp_w;
    par_t  <= par_w;
    ang_t  <= ang_w;

    if (deg_d) begin
      result.total_distance     <= '0;
      result.perpendicular_part <= '0;
      result.parallel_part      <= '0;
      result.angle_part         <= '0;
    end else begin
      result.total_distance     <= (tsum[WSUM_W-1:PART_W+8] != '0) ?
                                   PART_CAP[PART_W-1:0] : tsum[PART_W+7:8];
      result.perpendicular_part <= perp_t;
      result.parallel_part      <= par_t;
      result.angle_part         <= ang_t;
    end
    result.degenerate <= deg_d;
  end

  assign result_valid = vld[LV_OUT];

endmodule

[verif/weighted_segment_distance_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted segment distance core testbench
// Drives segment pairs through directed and random phases under several
// weight settings, predicts every result in exact wide arithmetic and
// checks each strobed result field by field.
// ----------------------------------------------------------------------------
module weighted_segment_distance_core_tb;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 220;
  localparam logic [127:0] ICAP = 128'h100_0000_0000;
  localparam logic [127:0] M32 = 128'hFFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t pair = '0;
  logic result_valid;
  out_item_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  logic [WEIGHT_W-1:0] w_perp = WEIGHT_RESET;
  logic [WEIGHT_W-1:0] w_par = WEIGHT_RESET;
  logic [WEIGHT_W-1:0] w_ang = WEIGHT_RESET;

  out_item_t expected_distances[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned degenerate_seen = 0;
  int idle_pct = 0;

  weighted_segment_distance_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pair(pair),
    .result_valid(result_valid), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [127:0] sx(logic signed [31:0] v);
    logic signed [127:0] r;
    r = v;
    return r;
  endfunction

  function automatic logic [127:0] mag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [127:0] div_cap(logic [127:0] n, logic [127:0] d,
                                           logic [127:0] cap);
    logic [127:0] q;
    q = n / d;
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic out_item_t predict_distance(in_item_t p);
    logic signed [127:0] dxa, dya, dxb, dyb, psx, psy, pex, pey;
    logic signed [127:0] la2, lb2, ds, de;
    logic [127:0] lena, lenb, da, db, m, perp, par, ang, tot;
    out_item_t r;
    dxa = sx(p.a_end_x) - sx(p.a_start_x);
    dya = sx(p.a_end_y) - sx(p.a_start_y);
    dxb = sx(p.b_end_x) - sx(p.b_start_x);
    dyb = sx(p.b_end_y) - sx(p.b_start_y);
    psx = sx(p.b_start_x) - sx(p.a_start_x);
    psy = sx(p.b_start_y) - sx(p.a_start_y);
    pex = sx(p.b_end_x) - sx(p.a_start_x);
    pey = sx(p.b_end_y) - sx(p.a_start_y);
    la2 = dxa * dxa + dya * dya;
    lb2 = dxb * dxb + dyb * dyb;
    r = '0;
    if (la2 == 0 || lb2 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    lena = floor_sqrt(la2);
    lenb = floor_sqrt(lb2);
    da = div_cap(mag(dxa * psy - dya * psx), lena, ICAP);
    db = div_cap(mag(dxa * pey - dya * pex), lena, ICAP);
    perp = (da + db == 0) ? 128'd0 : div_cap(da * da + db * db, da + db, M32);
    ds = dxa * psx + dya * psy;
    de = dxa * pex + dya * pey;
    m = mag(ds);
    if (mag(ds - la2) < m) m = mag(ds - la2);
    if (mag(de) < m) m = mag(de);
    if (mag(de - la2) < m) m = mag(de - la2);
    par = div_cap(m, lena, M32);
    ang = div_cap(mag(dxa * dyb - dya * dxb), lenb, ICAP);
    if (ang > lena) ang = lena;
    if (ang > M32) ang = M32;
    tot = (w_perp * perp + w_par * par + w_ang * ang) >> 8;
    if (tot > M32) tot = M32;
    r.total_distance = tot[31:0];
    r.perpendicular_part = perp[31:0];
    r.parallel_part = par[31:0];
    r.angle_part = ang[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && start && !busy) expected_distances.push_back(predict_distance(pair));
    if (!rst && result_valid) begin
      results_seen <= results_seen + 1;
      if (result.degenerate) degenerate_seen <= degenerate_seen + 1;
      if (expected_distances.size() == 0) begin
        $error("result with no pending item");
        mismatches++;
      end else begin
        out_item_t e;
        e = expected_distances.pop_front();
        if (e.total_distance !== result.total_distance) begin
          $error("total_distance exp %0h got %0h", e.total_distance, result.total_distance);
          mismatches++;
        end
        if (e.perpendicular_part !== result.perpendicular_part) begin
          $error("perpendicular_part exp %0h got %0h",
                 e.perpendicular_part, result.perpendicular_part);
          mismatches++;
        end
        if (e.parallel_part !== result.parallel_part) begin
          $error("parallel_part exp %0h got %0h", e.parallel_part, result.parallel_part);
          mismatches++;
        end
        if (e.angle_part !== result.angle_part) begin
          $error("angle_part exp %0h got %0h", e.angle_part, result.angle_part);
          mismatches++;
        end
        if (e.degenerate !== result.degenerate) begin
          $error("degenerate exp %0b got %0b", e.degenerate, result.degenerate);
          mismatches++;
        end
      end
    end
  end

  task automatic send_pair(in_item_t p);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    pair <= p;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    wait (expected_distances.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WEIGHT_PERP: w_perp = val;
      REG_WEIGHT_PAR: w_par = val;
      REG_WEIGHT_ANG: w_ang = val;
      default: ;
    endcase
  endtask

  task automatic set_weights(logic [WEIGHT_W-1:0] wp, logic [WEIGHT_W-1:0] wl,
                             logic [WEIGHT_W-1:0] wa);
    write_weight(REG_WEIGHT_PERP, wp);
    write_weight(REG_WEIGHT_PAR, wl);
    write_weight(REG_WEIGHT_ANG, wa);
  endtask

  function automatic in_item_t make_pair(logic signed [31:0] v0, logic signed [31:0] v1,
                                         logic signed [31:0] v2, logic signed [31:0] v3,
                                         logic signed [31:0] v4, logic signed [31:0] v5,
                                         logic signed [31:0] v6, logic signed [31:0] v7);
    in_item_t p;
    p.a_start_x = v0; p.a_start_y = v1; p.a_end_x = v2; p.a_end_y = v3;
    p.b_start_x = v4; p.b_start_y = v5; p.b_end_x = v6; p.b_end_y = v7;
    return p;
  endfunction

  function automatic logic signed [31:0] rand_coord(int shift);
    return $signed($urandom) >>> shift;
  endfunction

  function automatic in_item_t random_pair();
    in_item_t p;
    int kind;
    int sh;
    logic signed [31:0] dx, dy, k;
    kind = $urandom_range(99);
    sh = $urandom_range(0, 24);
    p = make_pair(rand_coord(sh), rand_coord(sh), rand_coord(sh), rand_coord(sh),
                  rand_coord(sh), rand_coord(sh), rand_coord(sh), rand_coord(sh));
    if (kind < 5) begin
      p.a_end_x = p.a_start_x; p.a_end_y = p.a_start_y;
    end else if (kind < 10) begin
      p.b_end_x = p.b_start_x; p.b_end_y = p.b_start_y;
    end else if (kind < 25) begin
      // B placed on the line through A.
      p.a_start_x = rand_coord(4); p.a_start_y = rand_coord(4);
      dx = rand_coord(20); dy = rand_coord(20);
      p.a_end_x = p.a_start_x + dx; p.a_end_y = p.a_start_y + dy;
      k = $signed($urandom_range(0, 8)) - 4;
      p.b_start_x = p.a_start_x + k * dx; p.b_start_y = p.a_start_y + k * dy;
      k = $signed($urandom_range(0, 8)) - 4;
      p.b_end_x = p.a_start_x + k * dx; p.b_end_y = p.a_start_y + k * dy;
    end else if (kind < 35) begin
      // Parallel segments with an offset.
      p.b_end_x = p.b_start_x + (p.a_end_x - p.a_start_x);
      p.b_end_y = p.b_start_y + (p.a_end_y - p.a_start_y);
    end
    return p;
  endfunction

  task automatic test_directed();
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    send_pair(make_pair(0, 0, 0, 0, 0, 0, ONE, ONE));
    send_pair(make_pair(0, 0, ONE, 0, ONE, ONE, ONE, ONE));
    send_pair(make_pair(5, 5, 5, 5, 7, 7, 7, 7));
    send_pair(make_pair(0, 0, ONE, 0, 0, 0, ONE, 0));
    send_pair(make_pair(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0));
    send_pair(make_pair(0, 0, ONE, 0, -ONE, 0, 4 * ONE, 0));
    send_pair(make_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE));
    send_pair(make_pair(0, 0, ONE, 0, 0, 0, 0, ONE));
    send_pair(make_pair(0, 0, ONE, 0, ONE, -ONE, ONE, ONE));
    send_pair(make_pair(MN, MN, MX, MX, MX, MN, MN, MX));
    send_pair(make_pair(MX, MX, MN, MN, MN, MX, MX, MN));
    send_pair(make_pair(MN, MN, MN, MX, MX, MX, MX, MN));
    send_pair(make_pair(MN, 0, MN + 1, 0, MX, MX, MN, MN));
    send_pair(make_pair(0, 0, 1, 0, MX, MX, MN, MX));
    send_pair(make_pair(0, 0, 1, 1, MN, MX, MX, MN));
    send_pair(make_pair(MX, MX, MX, MX, MN, MN, MX, MX));
    send_pair(make_pair(-1, -1, 0, 0, 1, 1, 2, 2));
    send_pair(make_pair(-ONE, 3, 7 * ONE, -2 * ONE, 9, -9, -5 * ONE, ONE));
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      send_pair(random_pair());
    end
    idle_pct = 0;
  endtask

  task automatic test_weights();
    set_weights(16'h0000, 16'h0000, 16'h0000);
    test_directed();
    test_random(60, 12);
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_directed();
    test_random(100, 67);
    write_weight(REG_UNUSED, 16'h1234);
    test_random(40, 0);
    set_weights(16'h0100, 16'h0000, 16'hFFFF);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_weights();
    test_random(600, 12);
    set_weights(16'($urandom), 16'($urandom), 16'($urandom));
    test_random(600, 67);
    set_weights(WEIGHT_RESET, 16'h0080, 16'h0300);
    test_random(600, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d segment pairs, %0d results, %0d degenerate, several weight sets.",
             items_sent, results_seen, degenerate_seen);
    if (mismatches == 0 && expected_distances.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/wsd_pkg.sv
rtl/core/wsd_delay.sv
rtl/core/wsd_mul.sv
rtl/core/wsd_sqrt.sv
rtl/core/wsd_div.sv
rtl/core/weighted_segment_distance_core.sv
verif/weighted_segment_distance_core_tb.sv
